### sv/slin_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slin_pkg
// command, status and cell operation codes shared by the sorted table
// ----------------------------------------------------------------------------
package slin_pkg;

    localparam logic [1:0] CMD_REMOVE = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DUMP     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
    } cell_ctl_t;

endpackage
`default_nettype wire

### sv/slin_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slin_cell
// one slot of the sorted chain: holds a key, compares it against the request
// key and takes its own, a neighbor's, the head's or the request key each cycle
// ----------------------------------------------------------------------------
module slin_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 7
) (
    input  wire logic               clk,
    input  wire slin_pkg::cell_ctl_t ctl,
    input  wire logic [CW-1:0]      count,
    input  wire logic signed [31:0] prev_entry,
    input  wire logic               prev_after,
    input  wire logic               prev_ge,
    input  wire logic signed [31:0] next_entry,
    input  wire logic signed [31:0] head_entry,
    output logic signed [31:0]      entry,
    output logic                    after,
    output logic                    ge,
    output logic                    hit
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               valid;
    logic               tail;

    assign valid = IDX < count;
    assign tail  = (IDX + CW'(1)) == count;
    assign entry = entry_reg;
    assign after = !valid || (entry_reg > ctl.key);
    assign ge    = valid && (entry_reg >= ctl.key);
    assign hit   = ge && !prev_ge && (entry_reg == ctl.key);

    always_comb
    begin
        case (ctl.op)
            slin_pkg::OP_INSERT:
            begin
                if (after)
                    entry_next = prev_after ? prev_entry : ctl.key;
                else
                    entry_next = entry_reg;
            end
            slin_pkg::OP_REMOVE:
            begin
                entry_next = ge ? next_entry : entry_reg;
            end
            slin_pkg::OP_ROTATE:
            begin
                entry_next = tail ? head_entry : next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

### sv/sorted_list_insert_remove_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top
// ascending table of signed keys with insert, remove and ordered dump
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_valid/in_stall  cmd, key
//  out      out_valid/out_stall value, status, last, occupancy
//
//  insert and remove update the cell chain when accepted; one result each
//  a dump delivers the head slot and rotates the chain once per result;
//  an empty table gives a single empty-status result instead
//  reset clears the fill count and the control only; slots hold no reset
//  a stalled result holds in the output register; input waits while it holds
//  a stalled result or while a dump is running
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         cmd,
    input  wire logic signed [31:0] key,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      value,
    output logic [2:0]              status,
    output logic                    last,
    output logic [6:0]              occupancy
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       dump_idx_reg, dump_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [31:0]  value_reg, value_next;
    logic [2:0]          status_reg, status_next;
    logic                last_reg, last_next;
    logic [CW-1:0]       occ_reg, occ_next;

    slin_pkg::cell_ctl_t ctl;
    logic signed [31:0]  entries [DEPTH];
    logic [DEPTH-1:0]    after_vec, ge_vec, hit_vec;
    logic                accept, out_free, full, found, dump_fire, dump_end;
    logic [CW+6:0]       occ_ext;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg == S_DUMP) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign full      = count_reg == CW'(DEPTH);
    assign found     = |hit_vec;
    assign dump_fire = (state_reg == S_DUMP) && out_free;
    assign dump_end  = dump_idx_reg == (count_reg - CW'(1));

    always_comb
    begin
        ctl.key = key;
        ctl.op  = slin_pkg::OP_HOLD;
        if (dump_fire)
            ctl.op = slin_pkg::OP_ROTATE;
        else if (accept && cmd == slin_pkg::CMD_INSERT && !full)
            ctl.op = slin_pkg::OP_INSERT;
        else if (accept && cmd == slin_pkg::CMD_REMOVE && found)
            ctl.op = slin_pkg::OP_REMOVE;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        slin_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .prev_entry ((i == 0) ? key : entries[(i == 0) ? 0 : i - 1]),
            .prev_after ((i == 0) ? 1'b0 : after_vec[(i == 0) ? 0 : i - 1]),
            .prev_ge    ((i == 0) ? 1'b0 : ge_vec[(i == 0) ? 0 : i - 1]),
            .next_entry (entries[(i == DEPTH - 1) ? i : i + 1]),
            .head_entry (entries[0]),
            .entry      (entries[i]),
            .after      (after_vec[i]),
            .ge         (ge_vec[i]),
            .hit        (hit_vec[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        occ_next       = occ_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next = key;
                    last_next  = 1'b1;
                    occ_next   = count_reg;
                    case (cmd)
                        slin_pkg::CMD_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                                status_next = slin_pkg::ST_FULL;
                            else
                            begin
                                status_next = slin_pkg::ST_DONE;
                                count_next  = count_reg + CW'(1);
                                occ_next    = count_reg + CW'(1);
                            end
                        end
                        slin_pkg::CMD_REMOVE:
                        begin
                            out_valid_next = 1'b1;
                            if (found)
                            begin
                                status_next = slin_pkg::ST_DONE;
                                count_next  = count_reg - CW'(1);
                                occ_next    = count_reg - CW'(1);
                            end
                            else
                                status_next = slin_pkg::ST_NOTFOUND;
                        end
                        slin_pkg::CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                value_next     = '0;
                                status_next    = slin_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (dump_fire)
                begin
                    out_valid_next = 1'b1;
                    value_next     = entries[0];
                    status_next    = slin_pkg::ST_DUMP;
                    last_next      = dump_end;
                    occ_next       = count_reg;
                    dump_idx_next  = dump_idx_reg + CW'(1);
                    if (dump_end)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        occ_reg    <= occ_next;
    end

    assign occ_ext   = {7'd0, occ_reg};
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign last      = last_reg;
    assign occupancy = occ_ext[6:0];

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_dump_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> in_stall && count_reg != '0)
        else $error("request taken during dump");

    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == slin_pkg::CMD_INSERT && full
        |=> out_valid_reg && status_reg == slin_pkg::ST_FULL && $stable(count_reg))
        else $error("full insert changed the table");

    a_dump_last : assert property (@(posedge clk) disable iff (!rst_n)
        dump_fire && dump_end |=> state_reg == S_IDLE && last_reg)
        else $error("dump end not marked");

endmodule
`default_nettype wire
